[rtl/stc_pkg.sv]
`default_nettype none

package stc_pkg;

    localparam int COLUMN_BITS_DEF = 12;
    localparam int NUM_STOPS       = 6;
    localparam int STOP_BITS       = 12;
    localparam int INC_BITS        = 8;
    localparam int CNT_BITS        = 3;
    localparam int CHAR_BITS       = 8;
    localparam int LEAD_BITS       = 12;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 12;
    localparam int OUT_DATA_BITS   = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_COUNT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAB_INCREMENT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_A        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_B        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_C        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_D        = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_E        = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_F        = 3'd7;

    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_BITS-1:0] CH_BLANK   = 8'd32;

    localparam logic [INC_BITS-1:0] DEFAULT_INCREMENT = 8'd8;

    typedef struct packed {
        logic [CNT_BITS-1:0]                   stop_count;
        logic [INC_BITS-1:0]                   tab_increment;
        logic [NUM_STOPS-1:0][STOP_BITS-1:0]   stops;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/stc_cfg_regs.sv]
`default_nettype none

module stc_cfg_regs
    import stc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                          cfg,
    output logic                          restart
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic restart_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_STOP_COUNT:    cfg_next.stop_count    = wr_data[CNT_BITS-1:0];
                REG_TAB_INCREMENT: cfg_next.tab_increment = wr_data[INC_BITS-1:0];
                REG_STOP_A:        cfg_next.stops[0]      = wr_data[STOP_BITS-1:0];
                REG_STOP_B:        cfg_next.stops[1]      = wr_data[STOP_BITS-1:0];
                REG_STOP_C:        cfg_next.stops[2]      = wr_data[STOP_BITS-1:0];
                REG_STOP_D:        cfg_next.stops[3]      = wr_data[STOP_BITS-1:0];
                REG_STOP_E:        cfg_next.stops[4]      = wr_data[STOP_BITS-1:0];
                REG_STOP_F:        cfg_next.stops[5]      = wr_data[STOP_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_count    <= '0;
            cfg_reg.tab_increment <= DEFAULT_INCREMENT;
            cfg_reg.stops         <= '0;
            restart_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            // every write restarts the line in the following cycle, with the new values
            restart_reg <= wr_en;
        end
    end

    assign cfg     = cfg_reg;
    assign restart = restart_reg;

endmodule

`default_nettype wire

[rtl/stc_stop_search.sv]
`default_nettype none

module stc_stop_search
    import stc_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  wire cfg_t                     cfg,
    input  wire logic [COLUMN_BITS-1:0]   from_col,
    input  wire logic [CNT_BITS-1:0]      start_index,
    output logic      [COLUMN_BITS-1:0]   stop_col,
    output logic      [CNT_BITS-1:0]      stop_index
);

    localparam int CMP_BITS = (COLUMN_BITS > STOP_BITS ? COLUMN_BITS : STOP_BITS) + 1;
    localparam logic [CMP_BITS-1:0] COL_MAX =
        {{(CMP_BITS-COLUMN_BITS){1'b0}}, {COLUMN_BITS{1'b1}}};

    logic [CNT_BITS-1:0]  cnt_eff;
    logic [INC_BITS-1:0]  inc_eff;
    logic [NUM_STOPS-1:0] hit;
    logic                 found;
    logic [STOP_BITS-1:0] pick;
    logic [CNT_BITS-1:0]  pick_index;
    logic [CMP_BITS-1:0]  cand;

    assign cnt_eff = (cfg.stop_count > CNT_BITS'(NUM_STOPS)) ? CNT_BITS'(NUM_STOPS)
                                                             : cfg.stop_count;
    assign inc_eff = (cfg.tab_increment == '0) ? INC_BITS'(1) : cfg.tab_increment;

    // entries at or below from_col are skipped
    always_comb
    begin
        for (int i = 0; i < NUM_STOPS; i++)
        begin
            hit[i] = (CNT_BITS'(i) >= start_index) && (CNT_BITS'(i) < cnt_eff) &&
                     (CMP_BITS'(cfg.stops[i]) > CMP_BITS'(from_col));
        end
    end

    // lowest hit wins
    always_comb
    begin
        found      = 1'b0;
        pick       = '0;
        pick_index = cnt_eff;
        for (int i = NUM_STOPS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found      = 1'b1;
                pick       = cfg.stops[i];
                pick_index = CNT_BITS'(i);
            end
        end
    end

    assign cand = found ? CMP_BITS'(pick) : CMP_BITS'(from_col) + CMP_BITS'(inc_eff);

    assign stop_col   = (cand > COL_MAX) ? {COLUMN_BITS{1'b1}} : cand[COLUMN_BITS-1:0];
    assign stop_index = pick_index;

endmodule

`default_nettype wire

[rtl/stc_core.sv]
`default_nettype none

module stc_core
    import stc_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfg_t                     cfg,
    input  wire logic                     restart,
    input  wire logic                     consume,
    input  wire logic [CHAR_BITS-1:0]     in_char,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic      [OUT_DATA_BITS-1:0] out_data
);

    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    logic [COLUMN_BITS-1:0] column_reg,     column_next;
    logic [COLUMN_BITS-1:0] printed_reg,    printed_next;
    logic [COLUMN_BITS-1:0] next_stop_reg,  next_stop_next;
    logic [CNT_BITS-1:0]    stop_index_reg, stop_index_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [LEAD_BITS-1:0]   lead_reg,       lead_next;
    logic [CHAR_BITS-1:0]   char_reg,       char_next;

    logic                   line_restart;
    logic                   emit;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [COLUMN_BITS-1:0] search_from;
    logic [CNT_BITS-1:0]    search_start;
    logic [COLUMN_BITS-1:0] found_stop;
    logic [CNT_BITS-1:0]    found_index;

    assign line_restart = restart || (consume && (in_char == CH_NEWLINE));
    assign search_from  = line_restart ? '0 : next_stop_reg;
    assign search_start = line_restart ? '0 : stop_index_reg;
    assign col_inc      = (column_reg == COL_MAX) ? column_reg
                                                  : column_reg + COLUMN_BITS'(1);

    stc_stop_search #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_search (
        .cfg         (cfg),
        .from_col    (search_from),
        .start_index (search_start),
        .stop_col    (found_stop),
        .stop_index  (found_index)
    );

    always_comb
    begin
        column_next     = column_reg;
        printed_next    = printed_reg;
        next_stop_next  = next_stop_reg;
        stop_index_next = stop_index_reg;
        lead_next       = lead_reg;
        char_next       = char_reg;
        emit            = 1'b0;

        if (line_restart)
        begin
            column_next     = '0;
            printed_next    = '0;
            next_stop_next  = found_stop;
            stop_index_next = found_index;
            if (!restart)
            begin
                emit      = 1'b1;
                lead_next = '0;
                char_next = CH_NEWLINE;
            end
        end
        else if (consume)
        begin
            priority if (in_char == CH_TAB)
            begin
                column_next     = next_stop_reg;
                printed_next    = next_stop_reg;
                next_stop_next  = found_stop;
                stop_index_next = found_index;
                emit            = 1'b1;
                lead_next       = '0;
                char_next       = CH_TAB;
            end
            else if (in_char == CH_BLANK)
            begin
                column_next = col_inc;
                // blank landing on the stop swallows the pending blanks
                if (col_inc == next_stop_reg)
                begin
                    printed_next    = next_stop_reg;
                    next_stop_next  = found_stop;
                    stop_index_next = found_index;
                    emit            = 1'b1;
                    lead_next       = '0;
                    char_next       = CH_TAB;
                end
            end
            else
            begin
                emit         = 1'b1;
                lead_next    = LEAD_BITS'(column_reg - printed_reg);
                char_next    = in_char;
                column_next  = col_inc;
                printed_next = col_inc;
                if (col_inc >= next_stop_reg)
                begin
                    next_stop_next  = found_stop;
                    stop_index_next = found_index;
                end
            end
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            printed_reg    <= '0;
            next_stop_reg  <= COLUMN_BITS'(DEFAULT_INCREMENT);
            stop_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg     <= column_next;
            printed_reg    <= printed_next;
            next_stop_reg  <= next_stop_next;
            stop_index_reg <= stop_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lead_reg <= lead_next;
        char_reg <= char_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_DATA_BITS-LEAD_BITS-CHAR_BITS){1'b0}}, char_reg, lead_reg};

endmodule

`default_nettype wire

[rtl/space_to_tab_converter.sv]
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata[7:0] in_char
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata[11:0] lead_spaces, [19:12] out_char
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One byte per cycle sustained; each byte passes the input register, then its result is registered.
// The cycle time is set by the stop search: six parallel compares, a priority pick
// and one add with saturation ahead of the line state registers.
// Reset clears the line state and loads the register defaults (tab every 8 columns).
// A register write holds byte processing while the line restarts.
// m_axis_tready low stalls processing while a result is held; one byte still waits in the input register.
`default_nettype none

module space_to_tab_converter
    import stc_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [CHAR_BITS-1:0]     s_axis_tdata,   // [7:0] in_char
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [OUT_DATA_BITS-1:0] m_axis_tdata,   // [11:0] lead_spaces, [19:12] out_char
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                 in_valid_reg, in_valid_next;
    logic [CHAR_BITS-1:0] in_char_reg;
    logic                 consume;
    logic                 restart;
    cfg_t                 cfg;

    assign cfg_ready = 1'b1;

    stc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .restart  (restart)
    );

    // advance the held byte when the result register is free or draining and the line is not restarting
    assign consume       = in_valid_reg && !restart && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;
    assign in_valid_next = (s_axis_tvalid && s_axis_tready) ? 1'b1
                                                            : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
        end
    end

    stc_core #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (restart),
        .consume   (consume),
        .in_char   (in_char_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        restart |-> !consume)
        else $error("byte consumed during line restart");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> restart)
        else $error("register write did not restart the line");

    a_newline_result: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && (in_char_reg == CH_NEWLINE)) |=>
        (m_axis_tvalid && (m_axis_tdata[LEAD_BITS +: CHAR_BITS] == CH_NEWLINE) &&
         (m_axis_tdata[LEAD_BITS-1:0] == '0)))
        else $error("newline request gave no newline result");

    a_ordinary_result: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && (in_char_reg != CH_BLANK)) |=> m_axis_tvalid)
        else $error("non-blank request gave no result");
`endif

endmodule

`default_nettype wire

[tb/space_to_tab_converter_tb.sv]
`timescale 1ns / 100ps

module space_to_tab_converter_tb;
    import stc_pkg::*;

    localparam int COLUMN_BITS     = COLUMN_BITS_DEF;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 157;
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_ROWS        = 26;

    typedef logic [COLUMN_BITS-1:0] col_t;
    localparam col_t COL_MAX = '1;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic [LEAD_BITS-1:0] lead;
    } tab_out_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] val;
        bit                       typed;
        logic [LEAD_BITS-1:0]     lead;
        logic [CHAR_BITS-1:0]     ch;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [CHAR_BITS-1:0]     s_axis_tdata = '0;      // [7:0] in_char
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;           // [11:0] lead_spaces, [19:12] out_char
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Line tracker state and register shadow
    logic [CNT_BITS-1:0]  cur_count;
    logic [INC_BITS-1:0]  cur_increment;
    logic [STOP_BITS-1:0] cur_stops [NUM_STOPS];
    col_t                 line_col;
    col_t                 line_printed;
    col_t                 line_next;
    logic [2:0]           line_idx;

    tab_out_t    due_outputs[$];
    int unsigned mismatch_count = 0;
    bit          gappy  = 1'b1;
    bit          choppy = 1'b1;
    bit          steady = 1'b0;

    space_to_tab_converter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic col_t col_sat(input logic [COLUMN_BITS:0] v);
        return (v > {1'b0, COL_MAX}) ? COL_MAX : v[COLUMN_BITS-1:0];
    endfunction

    // First stop strictly after 'from'; list entries at or below it are skipped.
    function automatic col_t next_tab_stop(input col_t from);
        int                   cnt;
        int                   idx;
        logic [COLUMN_BITS:0] inc;
        cnt = (cur_count > NUM_STOPS) ? NUM_STOPS : int'(cur_count);
        inc = (cur_increment == '0) ? (COLUMN_BITS+1)'(1)
                                    : (COLUMN_BITS+1)'(cur_increment);
        idx = line_idx;
        while (idx < cnt && cur_stops[idx] <= from)
            idx++;
        line_idx = idx[2:0];
        if (idx < cnt)
            return col_sat({1'b0, cur_stops[idx]});
        return col_sat({1'b0, from} + inc);
    endfunction

    function automatic void restart_line();
        line_col     = '0;
        line_printed = '0;
        line_idx     = '0;
        line_next    = next_tab_stop('0);
    endfunction

    function automatic void entab_reset();
        cur_count     = '0;
        cur_increment = DEFAULT_INCREMENT;
        foreach (cur_stops[i])
            cur_stops[i] = '0;
        restart_line();
    endfunction

    function automatic void entab_config(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            REG_STOP_COUNT:    cur_count     = val[CNT_BITS-1:0];
            REG_TAB_INCREMENT: cur_increment = val[INC_BITS-1:0];
            REG_STOP_A:        cur_stops[0]  = val;
            REG_STOP_B:        cur_stops[1]  = val;
            REG_STOP_C:        cur_stops[2]  = val;
            REG_STOP_D:        cur_stops[3]  = val;
            REG_STOP_E:        cur_stops[4]  = val;
            REG_STOP_F:        cur_stops[5]  = val;
            default: ;
        endcase
        restart_line();
    endfunction

    function automatic bit entab_step(input logic [CHAR_BITS-1:0] c, output tab_out_t r);
        r = '0;
        if (c == CH_NEWLINE)
        begin
            restart_line();
            r.ch = CH_NEWLINE;
            return 1'b1;
        end
        if (c == CH_TAB)
        begin
            line_col     = line_next;
            line_printed = line_next;
            line_next    = next_tab_stop(line_next);
            r.ch         = CH_TAB;
            return 1'b1;
        end
        if (c == CH_BLANK)
        begin
            line_col = col_sat({1'b0, line_col} + 1'b1);
            if (line_col == line_next)
            begin
                line_printed = line_next;
                line_next    = next_tab_stop(line_next);
                r.ch         = CH_TAB;
                return 1'b1;
            end
            return 1'b0;
        end
        r.lead       = LEAD_BITS'(line_col - line_printed);
        r.ch         = c;
        line_col     = col_sat({1'b0, line_col} + 1'b1);
        line_printed = line_col;
        if (line_col >= line_next)
            line_next = next_tab_stop(line_next);
        return 1'b1;
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_char(input int unsigned nl_permille);
        int unsigned r;
        r = $urandom_range(0, 999);
        if (r < nl_permille)
            return CH_NEWLINE;
        r = $urandom_range(0, 99);
        if (r < 45)
            return CH_BLANK;
        if (r < 55)
            return CH_TAB;
        if (r < 88)
            return CHAR_BITS'($urandom_range(33, 126));
        return CHAR_BITS'($urandom_range(0, 255));
    endfunction

    // Hold until every result is out and the pipeline has run dry
    task automatic settle();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        while (n < DRAIN_CYCLES)
        begin
            @(posedge clk);
            if (m_axis_tready)
                n++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        settle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        entab_config(idx, val);
    endtask

    task automatic push_byte(input logic [CHAR_BITS-1:0] ch, input bit typed,
                             input tab_out_t typed_r);
        tab_out_t r;
        bit       has_r;
        if (gappy && !steady && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tdata  <= ch;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has_r = entab_step(ch, r);
        if (typed)
            due_outputs.push_back(typed_r);
        else if (has_r)
            due_outputs.push_back(r);
    endtask

    task automatic load_phase(input int p);
        logic [CFG_DATA_BITS-1:0] val;
        logic [CNT_BITS-1:0]      cnt;
        logic [INC_BITS-1:0]      inc;
        int unsigned              acc;
        bit                       scatter;
        scatter = ($urandom_range(0, 3) == 0);
        case (p)
            0:       begin cnt = 3'd0; inc = 8'd1;   acc = 0;                        end
            1:       begin cnt = 3'd6; inc = 8'd255; acc = $urandom_range(3800, 4095); end
            2:       begin cnt = 3'd7; inc = 8'd0;   acc = $urandom_range(0, 20);      end
            default:
            begin
                cnt = CNT_BITS'($urandom_range(0, 7));
                inc = ($urandom_range(0, 2) == 0) ? INC_BITS'($urandom_range(0, 255))
                                                  : INC_BITS'($urandom_range(1, 16));
                acc = $urandom_range(0, 20);
            end
        endcase
        val = CFG_DATA_BITS'($urandom());
        val[CNT_BITS-1:0] = cnt;
        write_reg(REG_STOP_COUNT, val);
        val = CFG_DATA_BITS'($urandom());
        val[INC_BITS-1:0] = inc;
        write_reg(REG_TAB_INCREMENT, val);
        for (int k = 0; k < NUM_STOPS; k++)
        begin
            if (p == 0)
                val = '0;
            else if (scatter && p > 2)
                val = CFG_DATA_BITS'($urandom());
            else
            begin
                val = (acc > 4095) ? 12'hFFF : CFG_DATA_BITS'(acc);
                acc += $urandom_range(0, 40);
            end
            write_reg(CFG_IDX_BITS'(REG_STOP_A + k), val);
        end
    endtask

    // Result side: stall in bursts unless the run is in a quiet stretch
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (choppy && !steady && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_out
        tab_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_outputs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got lead %0d char %0d",
                         $time, m_axis_tdata[11:0], m_axis_tdata[19:12]);
            end
            else
            begin
                want = due_outputs.pop_front();
                if (m_axis_tdata[11:0] !== want.lead)
                begin
                    mismatch_count++;
                    $display("%0t: lead_spaces expected %0d, got %0d",
                             $time, want.lead, m_axis_tdata[11:0]);
                end
                if (m_axis_tdata[19:12] !== want.ch)
                begin
                    mismatch_count++;
                    $display("%0t: out_char expected %0d, got %0d",
                             $time, want.ch, m_axis_tdata[19:12]);
                end
                if (m_axis_tdata[23:20] !== 4'h0)
                begin
                    mismatch_count++;
                    $display("%0t: tdata pad expected 0, got %h", $time, m_axis_tdata[23:20]);
                end
            end
        end
    end

    initial
    begin : main_seq
        dir_row_t    dir_rows [NUM_ROWS];
        tab_out_t    typed_r;
        int unsigned nl_permille;
        dir_rows = '{
            '{ROW_BYTE, '0, 12'h041, 1'b1, 12'd0, 8'h41},
            '{ROW_BYTE, '0, 12'h020, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, 12'h020, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, 12'h000, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, 12'h020, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, 12'h020, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, 12'h020, 1'b0, 12'd0, 8'h00},
            // fourth blank after the NUL byte lands on the default stop at column 8
            '{ROW_BYTE, '0, 12'h020, 1'b1, 12'd0, CH_TAB},
            '{ROW_BYTE, '0, 12'h0FF, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, {4'h0, CH_TAB},     1'b1, 12'd0, CH_TAB},
            '{ROW_BYTE, '0, {4'h0, CH_NEWLINE}, 1'b1, 12'd0, CH_NEWLINE},
            // count of 7 acts as 6, increment of 0 acts as 1; list has repeats and a drop
            '{ROW_CFG, REG_STOP_COUNT,    12'hFFF, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_TAB_INCREMENT, 12'h000, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_STOP_A,        12'h003, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_STOP_B,        12'h003, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_STOP_C,        12'h001, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_STOP_D,        12'hFFE, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_STOP_E,        12'hFFF, 1'b0, 12'd0, 8'h00},
            '{ROW_CFG, REG_STOP_F,        12'h000, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, 12'h020, 1'b0, 12'd0, 8'h00},
            '{ROW_BYTE, '0, {4'h0, CH_TAB}, 1'b1, 12'd0, CH_TAB},
            '{ROW_BYTE, '0, {4'h0, CH_TAB}, 1'b1, 12'd0, CH_TAB},
            '{ROW_BYTE, '0, {4'h0, CH_TAB}, 1'b1, 12'd0, CH_TAB},
            // column and stop both stuck at the right edge
            '{ROW_BYTE, '0, 12'h020, 1'b1, 12'd0, CH_TAB},
            '{ROW_BYTE, '0, 12'h07A, 1'b1, 12'd0, 8'h7A},
            '{ROW_BYTE, '0, {4'h0, CH_NEWLINE}, 1'b1, 12'd0, CH_NEWLINE}
        };
        entab_reset();
        wait (rst_n);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
            begin
                typed_r.lead = dir_rows[i].lead;
                typed_r.ch   = dir_rows[i].ch;
                push_byte(dir_rows[i].val[CHAR_BITS-1:0], dir_rows[i].typed, typed_r);
            end
        end

        typed_r = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            gappy  = ($urandom_range(0, 3) != 0);
            choppy = ($urandom_range(0, 3) != 0);
            if (p == NUM_PHASES - 1)
                steady = 1'b1;
            load_phase(p);
            // long lines where the stops sit far out, and at random in other phases
            nl_permille = (p == 1 || $urandom_range(0, 3) == 0) ? 2 : 30;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_byte(pick_char(nl_permille), 1'b0, typed_r);
        end

        settle();
        if (mismatch_count == 0 && due_outputs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
